// ----- hdl/gst_pkg.sv -----
// ----------------------------------------------------------------------------
// gst_pkg - shared constants and functions for the Gaussian specular texel unit
// Holds the fixed-point widths, the CORDIC arctangent table, the integer
// exponential table and the helper functions used by the pipeline stages.
// ----------------------------------------------------------------------------
package gst_pkg;

	localparam int MaxCosRes  = 4096;
	localparam int MaxShinRes = 256;
	localparam int FracBits   = 16;
	localparam int WorkQ      = 30;
	localparam int CordicSteps = 30;
	localparam int TaylorTerms = 14;
	localparam int ExpLimit   = 6;

	localparam int CosResW  = 13;
	localparam int ShinResW = 9;
	localparam int RowW     = 9;
	localparam int ColW     = 12;
	localparam int OutW     = 8;

	localparam logic [0:0] RegCosRes  = 1'b0;
	localparam logic [0:0] RegShinRes = 1'b1;

	// arctangent of 2^-i in Q2.30
	function automatic logic signed [33:0] atan_step(input int i);
		logic signed [33:0] r;
		r = '0;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: r = 34'sd1 <<< (WorkQ - i);
		endcase
		return r;
	endfunction

	// exp(-n) in Q2.30
	function automatic logic [31:0] exp_neg_int(input logic [2:0] n);
		logic [31:0] r;
		r = '0;
		case (n)
			3'd0: r = 32'd1073741824;
			3'd1: r = 32'd395007542;
			3'd2: r = 32'd145315154;
			3'd3: r = 32'd53458458;
			3'd4: r = 32'd19666268;
			3'd5: r = 32'd7234816;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/gst_divider.sv -----
// ----------------------------------------------------------------------------
// gst_divider - pipelined restoring divider
// One quotient bit per stage; a side band of width TagW travels alongside.
// ----------------------------------------------------------------------------
module gst_divider #(
	parameter int NumW = 28,
	parameter int DenW = 13,
	parameter int TagW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NumW-1:0]  num,
	input  logic [DenW-1:0]  den,
	input  logic [TagW-1:0]  tag_in,
	output logic             out_valid,
	output logic [NumW-1:0]  quot,
	output logic [TagW-1:0]  tag_out
);

	logic [NumW-1:0] rem_s [NumW+1];
	logic [NumW-1:0] q_s   [NumW+1];
	logic [NumW-1:0] n_s   [NumW+1];
	logic [DenW-1:0] d_s   [NumW+1];
	logic [TagW-1:0] t_s   [NumW+1];
	logic            v_s   [NumW+1];

	assign rem_s[0] = '0;
	assign q_s[0]   = '0;
	assign n_s[0]   = num;
	assign d_s[0]   = den;
	assign t_s[0]   = tag_in;
	assign v_s[0]   = in_valid;

	for (genvar k = 0; k < NumW; k++) begin : g_bit
		logic [NumW:0] trial;
		logic [NumW:0] shifted;
		assign shifted = {rem_s[k], n_s[k][NumW-1-k]};
		assign trial   = shifted - {{(NumW+1-DenW){1'b0}}, d_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[NumW]) begin
					rem_s[k+1] <= trial[NumW-1:0];
					q_s[k+1]   <= {q_s[k][NumW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= shifted[NumW-1:0];
					q_s[k+1]   <= {q_s[k][NumW-2:0], 1'b0};
				end
				n_s[k+1] <= n_s[k];
				d_s[k+1] <= d_s[k];
				t_s[k+1] <= t_s[k];
			end
		end
	end

	assign out_valid = v_s[NumW];
	assign quot      = q_s[NumW];
	assign tag_out   = t_s[NumW];

endmodule

// ----- hdl/gst_acos.sv -----
// ----------------------------------------------------------------------------
// gst_acos - acos of a Q1.16 cosine, pipelined
// Integer square root (one result bit per stage) then 30 CORDIC vectoring
// stages; output angle in Q1.16.
// ----------------------------------------------------------------------------
module gst_acos #(
	parameter int TagW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [gst_pkg::FracBits:0] c_in,
	input  logic [TagW-1:0]        tag_in,
	output logic                   out_valid,
	output logic [gst_pkg::FracBits:0] angle,
	output logic [TagW-1:0]        tag_out
);

	localparam int F    = gst_pkg::FracBits;
	localparam int SqW  = 2*F + 2;
	localparam int SqN  = F + 1;
	localparam int N    = gst_pkg::CordicSteps;
	localparam int XW   = F + 4;
	localparam int ZW   = 34;

	// square root of (1<<2F) - c*c, bit pair per stage, from the top
	logic [SqW-1:0] rad_s [SqN+1];
	logic [SqW-1:0] rem_s [SqN+1];
	logic [F:0]     root_s [SqN+1];
	logic [F:0]     c_s   [SqN+1];
	logic [TagW-1:0] ts_s [SqN+1];
	logic           vs_s  [SqN+1];

	logic [2*F+1:0] c_sq;
	assign c_sq = c_in * c_in;

	assign rad_s[0]  = SqW'((2*F+2)'(1) << (2*F)) - SqW'(c_sq);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign c_s[0]    = c_in;
	assign ts_s[0]   = tag_in;
	assign vs_s[0]   = in_valid;

	for (genvar k = 0; k < SqN; k++) begin : g_sqrt
		logic [SqW+1:0] cur;
		logic [SqW+1:0] trial;
		assign cur   = {rem_s[k][SqW-1:0], rad_s[k][SqW-1 -: 2]} & {(SqW+2){1'b1}};
		assign trial = cur - {{(SqW-F-1){1'b0}}, root_s[k], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs_s[k+1] <= 1'b0;
			end else if (en) begin
				vs_s[k+1] <= vs_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= {rad_s[k][SqW-3:0], 2'b00};
				if (!trial[SqW+1]) begin
					rem_s[k+1]  <= trial[SqW-1:0];
					root_s[k+1] <= {root_s[k][F-1:0], 1'b1};
				end else begin
					rem_s[k+1]  <= cur[SqW-1:0];
					root_s[k+1] <= {root_s[k][F-1:0], 1'b0};
				end
				c_s[k+1]  <= c_s[k];
				ts_s[k+1] <= ts_s[k];
			end
		end
	end

	// CORDIC vectoring
	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 zero_s [N+1];
	logic [TagW-1:0]      tc_s [N+1];
	logic                 vc_s [N+1];

	assign x_s[0]    = XW'(signed'({1'b0, c_s[SqN]}));
	assign y_s[0]    = XW'(signed'({1'b0, root_s[SqN]}));
	assign z_s[0]    = '0;
	assign zero_s[0] = (root_s[SqN] == '0);
	assign tc_s[0]   = ts_s[SqN];
	assign vc_s[0]   = vs_s[SqN];

	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [XW-1:0] dx, dy;
		logic signed [ZW-1:0] at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = gst_pkg::atan_step(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_s[i+1] <= 1'b0;
			end else if (en) begin
				vc_s[i+1] <= vc_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][XW-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end
				zero_s[i+1] <= zero_s[i];
				tc_s[i+1]   <= tc_s[i];
			end
		end
	end

	logic signed [ZW-1:0] zf;
	assign zf = z_s[N];
	assign out_valid = vc_s[N];
	assign tag_out   = tc_s[N];
	always_comb begin
		if (zero_s[N] || zf[ZW-1]) begin
			angle = '0;
		end else begin
			angle = zf[gst_pkg::WorkQ-gst_pkg::FracBits +: F+1];
		end
	end

endmodule

// ----- hdl/gst_gauss.sv -----
// ----------------------------------------------------------------------------
// gst_gauss - floor(255*exp(-q)) for q in Q16.16, pipelined
// Two stages per Taylor term (multiply, then divide by a constant through a
// reciprocal multiply), then the integer exponential product and the scale
// by 255.
// ----------------------------------------------------------------------------
module gst_gauss (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic        big_in,
	input  logic [31:0] q_in,
	output logic        out_valid,
	output logic [7:0]  result
);

	localparam int F  = gst_pkg::FracBits;
	localparam int W  = gst_pkg::WorkQ;
	localparam int T  = gst_pkg::TaylorTerms;

	logic [W:0]          t_s   [T+1];
	logic signed [W+2:0] sum_s [T+1];
	logic [W-1:0]        f_s   [T+1];
	logic [2:0]          n_s   [T+1];
	logic                z_s   [T+1];
	logic                v_s   [T+1];

	// product half of each term
	logic [W-1:0]        pt_m  [T];
	logic signed [W+2:0] sum_m [T];
	logic [W-1:0]        f_m   [T];
	logic [2:0]          n_m   [T];
	logic                z_m   [T];
	logic                v_m   [T];

	logic [15:0] n_full;
	assign n_full  = q_in[31:F];
	assign t_s[0]  = (W+1)'(1) << W;
	assign sum_s[0] = (W+3)'(1) <<< W;
	assign f_s[0]  = W'(q_in[F-1:0]) << (W - F);
	assign n_s[0]  = n_full[2:0];
	assign z_s[0]  = big_in || (n_full >= 16'(gst_pkg::ExpLimit));
	assign v_s[0]  = in_valid;

	for (genvar k = 1; k <= T; k++) begin : g_term
		// the truncated product stays below 2^W, so this reciprocal is exact
		localparam int Sh = W + $clog2(k);
		localparam longint unsigned RecipK = ((64'd1 << Sh) / k) + 64'd1;
		logic [2*W:0]   p;
		logic [2*W+4:0] pm;
		logic [W:0]     tk;
		assign p  = t_s[k-1] * f_s[k-1];
		assign pm = (2*W+5)'(pt_m[k-1]) * (2*W+5)'(RecipK);
		assign tk = (W+1)'(pm >> Sh);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_m[k-1] <= 1'b0;
				v_s[k]   <= 1'b0;
			end else if (en) begin
				v_m[k-1] <= v_s[k-1];
				v_s[k]   <= v_m[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				pt_m[k-1]  <= p[W +: W];
				sum_m[k-1] <= sum_s[k-1];
				f_m[k-1]   <= f_s[k-1];
				n_m[k-1]   <= n_s[k-1];
				z_m[k-1]   <= z_s[k-1];
				t_s[k] <= tk;
				if (k % 2 == 1) begin
					sum_s[k] <= sum_m[k-1] - signed'({2'b00, tk});
				end else begin
					sum_s[k] <= sum_m[k-1] + signed'({2'b00, tk});
				end
				f_s[k] <= f_m[k-1];
				n_s[k] <= n_m[k-1];
				z_s[k] <= z_m[k-1];
			end
		end
	end

	// clamp sum, multiply by exp(-n)
	logic [W:0] sum_c;
	always_comb begin
		if (sum_s[T][W+2]) begin
			sum_c = '0;
		end else if (sum_s[T] > ((W+3)'(1) <<< W)) begin
			sum_c = (W+1)'(1) << W;
		end else begin
			sum_c = sum_s[T][W:0];
		end
	end

	logic [31:0] prod_p;
	logic        v_p, z_p;
	logic [63:0] pe;
	assign pe = gst_pkg::exp_neg_int(n_s[T]) * sum_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= 1'b0;
		end else if (en) begin
			v_p <= v_s[T];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_p <= pe[W +: 32];
			z_p    <= z_s[T];
		end
	end

	logic [39:0] r_full;
	logic [9:0]  r;
	assign r_full = 40'(prod_p) * 40'd255;
	assign r      = r_full[W +: 10];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_p;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (z_p) begin
				result <= '0;
			end else if (r > 10'd255) begin
				result <= 8'd255;
			end else begin
				result <= r[7:0];
			end
		end
	end

endmodule

// ----- hdl/gaussian_specular_table_texel_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_specular_table_texel_unit - one Gaussian specular table texel
// Streams texels of floor(255*exp(-(acos(c)/s)^2)) for a row/column pair.
// ----------------------------------------------------------------------------
// When nothing stalls, one texel is accepted every cycle. The pipeline has one
// stage for the index clamp, one per quotient bit of the two dividers (29 and
// 30), one per root bit (17), one per CORDIC step (30), one each for the
// shininess product and the square, two per Taylor term (28) and two for the
// exponential product and the scale by 255. A stall on the output freezes the
// whole pipeline, so in_stall follows out_stall while the output register holds
// a result. Write cos_resolution (index 0) and shininess_resolution (index 1)
// only while the unit is empty; shininess_resolution keeps only its low 9 bits,
// out-of-range values are saturated and indices are clamped to them.
module gaussian_specular_table_texel_unit #(
	parameter int MAX_COS_RES  = gst_pkg::MaxCosRes,
	parameter int MAX_SHIN_RES = gst_pkg::MaxShinRes
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  shininess_index,
	input  logic [11:0] cos_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  gaussian_value
);

	localparam int F = gst_pkg::FracBits;

	logic [12:0] cos_res_q;
	logic [8:0]  shin_res_q;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_res_q  <= 13'd512;
			shin_res_q <= 9'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				gst_pkg::RegCosRes:  cos_res_q  <= cfg_wdata;
				gst_pkg::RegShinRes: shin_res_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// advance whole pipeline when output is free
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: clamp
	logic [16:0] cres_c;
	logic [12:0] sres_c;
	logic [12:0] col_c;
	logic [12:0] row_c;
	always_comb begin
		cres_c = 17'(cos_res_q);
		if (cres_c < 17'd2) cres_c = 17'd2;
		if (cres_c > 17'(MAX_COS_RES)) cres_c = 17'(MAX_COS_RES);
		sres_c = 13'(shin_res_q);
		if (sres_c < 13'd1) sres_c = 13'd1;
		if (sres_c > 13'(MAX_SHIN_RES)) sres_c = 13'(MAX_SHIN_RES);
		col_c = 13'(cos_index);
		if (17'(col_c) > cres_c - 17'd1) col_c = 13'(cres_c - 17'd1);
		row_c = 13'(shininess_index);
		if (row_c < 13'd1) row_c = 13'd1;
		if (row_c > sres_c) row_c = sres_c;
	end

	logic        v_s1;
	logic [28:0] num_s1;
	logic [16:0] den_s1;
	logic [12:0] sres_s1, row_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= 29'(col_c) << F;
			den_s1  <= cres_c - 17'd1;
			sres_s1 <= sres_c;
			row_s1  <= row_c;
		end
	end

	// cosine divide
	logic        v_c;
	logic [28:0] c_full;
	logic [25:0] tag_c;
	gst_divider #(.NumW(29), .DenW(17), .TagW(26)) u_cdiv (
		.clk, .arst_n, .en,
		.in_valid(v_s1), .num(num_s1), .den(den_s1),
		.tag_in({sres_s1, row_s1}),
		.out_valid(v_c), .quot(c_full), .tag_out(tag_c)
	);

	logic        v_a;
	logic [F:0]  angle;
	logic [25:0] tag_a;
	gst_acos #(.TagW(26)) u_acos (
		.clk, .arst_n, .en,
		.in_valid(v_c), .c_in(c_full[F:0]), .tag_in(tag_c),
		.out_valid(v_a), .angle(angle), .tag_out(tag_a)
	);

	// stage: angle times shininess resolution
	logic        v_s2;
	logic [29:0] as_s2;
	logic [12:0] row_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_a;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			as_s2  <= 30'(angle) * 30'(tag_a[25:13]);
			row_s2 <= tag_a[12:0];
		end
	end

	logic        v_x;
	logic [29:0] x_full;
	logic        unused_tag;
	gst_divider #(.NumW(30), .DenW(13), .TagW(1)) u_xdiv (
		.clk, .arst_n, .en,
		.in_valid(v_s2), .num(as_s2), .den(row_s2), .tag_in(1'b0),
		.out_valid(v_x), .quot(x_full), .tag_out(unused_tag)
	);

	// stage: square x, drop to Q16.16
	logic        v_s3, big_s3;
	logic [31:0] q_s3;
	logic [37:0] xsq;
	assign xsq = 38'(x_full[18:0]) * 38'(x_full[18:0]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_x;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			big_s3 <= (x_full >= (30'd8 << F)) || unused_tag;
			q_s3   <= 32'(xsq >> F);
		end
	end

	gst_gauss u_gauss (
		.clk, .arst_n, .en,
		.in_valid(v_s3), .big_in(big_s3), .q_in(q_s3),
		.out_valid(out_valid), .result(gaussian_value)
	);

endmodule
